/* rtl/tpcd_pkg.sv */
package tpcd_pkg;

    localparam int PAD_COUNT    = 4;
    localparam int SAMPLE_LANES = 4;
    localparam int LIVE_PADS    = (PAD_COUNT < SAMPLE_LANES) ? PAD_COUNT : SAMPLE_LANES;

    localparam int WORD_W   = 16;
    localparam int OP_W     = 3;
    localparam int PAD_W    = 2;
    localparam int MASK_W   = 4;
    localparam int COLOUR_W = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [LIVE_PADS-1:0] t_thr_vec;
    typedef t_word [SAMPLE_LANES-1:0] t_sample_vec;

    localparam logic [OP_W-1:0] OP_START  = 3'd0;
    localparam logic [OP_W-1:0] OP_FRAME  = 3'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd3;
    localparam logic [OP_W-1:0] OP_DETECT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA         = 1'd1;

    localparam t_word WORD_ONES            = 16'hFFFF;
    localparam t_word DEFAULT_THRESHOLD_RST = 16'd40;
    localparam t_word MIN_DELTA_RST        = 16'd10;

    // Reciprocal of five scaled by 2^18; exact floor for dividends below 2^18.
    localparam int          RECIP_SHIFT = 18;
    localparam logic [15:0] RECIP_FIVE  = 16'd52429;

    localparam logic [COLOUR_W-1:0] COLOUR_MAX = 8'd255;
    localparam logic [COLOUR_W-1:0] COLOUR_RED   [SAMPLE_LANES] = '{8'd80, 8'd0, 8'd0, 8'd80};
    localparam logic [COLOUR_W-1:0] COLOUR_GREEN [SAMPLE_LANES] = '{8'd0, 8'd80, 8'd0, 8'd80};
    localparam logic [COLOUR_W-1:0] COLOUR_BLUE  [SAMPLE_LANES] = '{8'd0, 8'd0, 8'd80, 8'd80};

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [PAD_W-1:0] pad;
        t_word            stored_word;
        t_word            sample_zero;
        t_word            sample_one;
        t_word            sample_two;
        t_word            sample_three;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0]   pressed_mask;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic [MASK_W-1:0]   calibrated_mask;
    } t_out_item;

    typedef struct packed {
        t_word default_threshold;
        t_word min_delta;
    } t_cfg;

    function automatic t_sample_vec samples_of(input t_in_item item);
        t_sample_vec s;
        s[0] = item.sample_zero;
        s[1] = item.sample_one;
        s[2] = item.sample_two;
        s[3] = item.sample_three;
        return s;
    endfunction

endpackage

/* rtl/touch_pad_calibrate_and_detect_unit.sv */
// Channel  | Handshake                   | Payload
// in       | i_in_valid / o_in_ready     | i_in_data  (t_in_item)
// out      | o_out_valid / i_out_ready   | o_out_data (t_out_item)
// cfg      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Each item passes through the input register, then through the pad logic
// into the result register.
// A new item is taken every cycle while the result register drains.
// Reset puts all pads in the uncalibrated state with the default threshold.
// A stalled result holds the input register, which then stalls the input.
module touch_pad_calibrate_and_detect_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tpcd_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tpcd_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tpcd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  tpcd_pkg::t_word                    i_cfg_data
);
    import tpcd_pkg::*;

    logic      r_in_valid, r_out_valid;
    logic      n_in_valid, n_out_valid;
    t_in_item  r_in_item;
    t_out_item r_out_item, n_out_item;
    t_cfg      r_cfg;
    t_thr_vec  thr;
    t_out_item det_result;
    logic [MASK_W-1:0] cal_mask;
    logic      advance, in_fire;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    tpcd_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_item     (r_in_item),
        .i_cfg      (r_cfg),
        .o_thr      (thr),
        .o_cal_mask (cal_mask)
    );

    tpcd_detect u_detect (
        .i_item   (r_in_item),
        .i_thr    (thr),
        .o_result (det_result)
    );

    always_comb begin
        n_out_item = det_result;
        n_out_item.calibrated_mask = cal_mask;
        n_in_valid  = in_fire ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg.default_threshold <= DEFAULT_THRESHOLD_RST;
            r_cfg.min_delta         <= MIN_DELTA_RST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DEFAULT_THRESHOLD: r_cfg.default_threshold <= i_cfg_data;
                    REG_MIN_DELTA:         r_cfg.min_delta         <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

/* rtl/tpcd_state.sv */
module tpcd_state (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  tpcd_pkg::t_in_item      i_item,
    input  tpcd_pkg::t_cfg          i_cfg,
    output tpcd_pkg::t_thr_vec      o_thr,
    output logic [tpcd_pkg::MASK_W-1:0] o_cal_mask
);
    import tpcd_pkg::*;

    t_thr_vec    r_lo, r_hi, r_thr;
    t_thr_vec    n_lo, n_hi, n_thr;
    t_sample_vec samp;
    logic [MASK_W-1:0] cal_mask;

    always_comb begin
        logic        ok;
        t_word       spread;
        logic [16:0] spread2;
        logic [32:0] prod;
        logic [14:0] quot;
        t_word       adapt;
        samp     = samples_of(i_item);
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_thr    = r_thr;
        cal_mask = '0;
        for (int i = 0; i < LIVE_PADS; i++) begin
            spread  = r_hi[i] - r_lo[i];
            ok      = (r_hi[i] > r_lo[i]) && (spread >= i_cfg.min_delta);
            spread2 = {spread, 1'b0};
            prod    = spread2 * RECIP_FIVE;
            quot    = prod[32:RECIP_SHIFT];
            adapt   = r_lo[i] + {1'b0, quot};
            case (i_item.op)
                OP_START: begin
                    n_lo[i] = WORD_ONES;
                    n_hi[i] = '0;
                end
                OP_FRAME: begin
                    if (samp[i] < r_lo[i]) begin
                        n_lo[i] = samp[i];
                    end
                    if (samp[i] > r_hi[i]) begin
                        n_hi[i] = samp[i];
                    end
                end
                OP_FINISH: begin
                    n_thr[i]    = ok ? adapt : i_cfg.default_threshold;
                    cal_mask[i] = ok;
                end
                OP_LOAD: begin
                    if (i_item.pad == PAD_W'(i)) begin
                        if ((i_item.stored_word == '0) || (i_item.stored_word == WORD_ONES)) begin
                            n_thr[i] = i_cfg.default_threshold;
                        end else begin
                            n_thr[i] = i_item.stored_word;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIVE_PADS; i++) begin
                r_lo[i]  <= WORD_ONES;
                r_hi[i]  <= '0;
                r_thr[i] <= DEFAULT_THRESHOLD_RST;
            end
        end else if (i_en) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_thr <= n_thr;
        end
    end

    assign o_thr      = r_thr;
    assign o_cal_mask = cal_mask;

endmodule

/* rtl/tpcd_detect.sv */
module tpcd_detect (
    input  tpcd_pkg::t_in_item  i_item,
    input  tpcd_pkg::t_thr_vec  i_thr,
    output tpcd_pkg::t_out_item o_result
);
    import tpcd_pkg::*;

    t_sample_vec samp;

    always_comb begin
        logic [MASK_W-1:0]   pressed;
        logic [COLOUR_W+1:0] r_sum, g_sum, b_sum;
        samp    = samples_of(i_item);
        pressed = '0;
        r_sum   = '0;
        g_sum   = '0;
        b_sum   = '0;
        for (int i = 0; i < LIVE_PADS; i++) begin
            if (samp[i] < i_thr[i]) begin
                pressed[i] = 1'b1;
                r_sum = r_sum + {2'b00, COLOUR_RED[i]};
                g_sum = g_sum + {2'b00, COLOUR_GREEN[i]};
                b_sum = b_sum + {2'b00, COLOUR_BLUE[i]};
            end
        end
        o_result = '0;
        if (i_item.op == OP_DETECT) begin
            o_result.pressed_mask = pressed;
            o_result.red   = (r_sum > {2'b00, COLOUR_MAX}) ? COLOUR_MAX : r_sum[COLOUR_W-1:0];
            o_result.green = (g_sum > {2'b00, COLOUR_MAX}) ? COLOUR_MAX : g_sum[COLOUR_W-1:0];
            o_result.blue  = (b_sum > {2'b00, COLOUR_MAX}) ? COLOUR_MAX : b_sum[COLOUR_W-1:0];
        end
    end

endmodule

/* verif/touch_pad_calibrate_and_detect_unit_tb.sv */
`timescale 1ns / 1ps

module touch_pad_calibrate_and_detect_unit_tb;

    import tpcd_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PAD_LEVEL   = 80;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        t_word                value;
    } t_reg_write;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    t_reg_write cfg_word = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       o_cfg_ready;

    t_in_item   pending_items[$];
    t_out_item  pad_results_due[$];
    t_reg_write reg_writes[$];

    t_word      low_seen [PAD_COUNT];
    t_word      high_seen [PAD_COUNT];
    t_word      pad_thr [PAD_COUNT];
    t_word      cfg_default;
    t_word      cfg_delta;

    int         busy_pct = 0;
    int         send_gap = 0;
    int         recv_stall = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    touch_pad_calibrate_and_detect_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_word.idx),
        .i_cfg_data  (cfg_word.value)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic t_out_item apply_pad_op(t_in_item it);
        t_out_item res;
        t_word     smp [SAMPLE_LANES];
        t_word     thr;
        int        spread;
        int        r;
        int        g;
        int        b;
        res = '0;
        r = 0;
        g = 0;
        b = 0;
        smp[0] = it.sample_zero;
        smp[1] = it.sample_one;
        smp[2] = it.sample_two;
        smp[3] = it.sample_three;
        case (it.op)
            OP_START: begin
                for (int i = 0; i < PAD_COUNT; i++) begin
                    low_seen[i] = WORD_ONES;
                    high_seen[i] = '0;
                end
            end
            OP_FRAME: begin
                for (int i = 0; i < LIVE_PADS; i++) begin
                    if (smp[i] < low_seen[i]) low_seen[i] = smp[i];
                    if (smp[i] > high_seen[i]) high_seen[i] = smp[i];
                end
            end
            OP_FINISH: begin
                for (int i = 0; i < LIVE_PADS; i++) begin
                    thr = cfg_default;
                    if (high_seen[i] > low_seen[i]) begin
                        spread = int'(high_seen[i]) - int'(low_seen[i]);
                        if (spread >= int'(cfg_delta)) begin
                            thr = t_word'(int'(low_seen[i]) + (spread * 2) / 5);
                            res.calibrated_mask[i] = 1'b1;
                        end
                    end
                    pad_thr[i] = thr;
                end
            end
            OP_LOAD: begin
                if (int'(it.pad) < PAD_COUNT) begin
                    if (it.stored_word == '0 || it.stored_word == WORD_ONES) begin
                        pad_thr[it.pad] = cfg_default;
                    end else begin
                        pad_thr[it.pad] = it.stored_word;
                    end
                end
            end
            OP_DETECT: begin
                for (int i = 0; i < LIVE_PADS; i++) begin
                    if (smp[i] < pad_thr[i]) begin
                        res.pressed_mask[i] = 1'b1;
                        if (i == 0 || i == 3) r += PAD_LEVEL;
                        if (i == 1 || i == 3) g += PAD_LEVEL;
                        if (i == 2 || i == 3) b += PAD_LEVEL;
                    end
                end
                if (r > int'(COLOUR_MAX)) r = int'(COLOUR_MAX);
                if (g > int'(COLOUR_MAX)) g = int'(COLOUR_MAX);
                if (b > int'(COLOUR_MAX)) b = int'(COLOUR_MAX);
                res.red = r[COLOUR_W-1:0];
                res.green = g[COLOUR_W-1:0];
                res.blue = b[COLOUR_W-1:0];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_in_item build_item(logic [OP_W-1:0] op, logic [PAD_W-1:0] pad,
                                            t_word word, t_word s0, t_word s1,
                                            t_word s2, t_word s3);
        t_in_item it;
        it.op = op;
        it.pad = pad;
        it.stored_word = word;
        it.sample_zero = s0;
        it.sample_one = s1;
        it.sample_two = s2;
        it.sample_three = s3;
        return it;
    endfunction

    function automatic t_word rand_word();
        return t_word'($urandom_range(0, 65535));
    endfunction

    function automatic logic [PAD_W-1:0] rand_pad();
        return PAD_W'($urandom_range(0, 3));
    endfunction

    function automatic t_word near_reading(t_word base, int span);
        int v;
        if ($urandom_range(0, 9) == 0) return rand_word();
        v = int'(base) + int'($urandom_range(0, span));
        if (v > 65535) v = 65535;
        return t_word'(v);
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch at cycle %0d: %s expected %h got %h",
                 cycle_count, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : drive_items
        logic     nv;
        t_in_item nd;
        nv = in_valid;
        nd = in_data;
        if (in_valid && o_in_ready) begin
            pad_results_due.push_back(apply_pad_op(in_data));
            nv = 1'b0;
        end
        if (i_rst_n && !nv) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (busy_pct != 0 && $urandom_range(0, 99) < busy_pct) begin
                send_gap = $urandom_range(1, 10) - 1;
            end else if (pending_items.size() != 0) begin
                nv = 1'b1;
                nd = pending_items.pop_front();
            end
        end
        in_valid <= nv;
        in_data <= nd;
    end

    always @(posedge i_clk) begin : watch_results
        t_out_item want;
        logic      nr;
        if (o_out_valid && out_ready) begin
            if (pad_results_due.size() == 0) begin
                flag_mismatch("result with nothing due", '0, 32'(o_out_data));
            end else begin
                want = pad_results_due.pop_front();
                if (o_out_data.pressed_mask !== want.pressed_mask)
                    flag_mismatch("pressed_mask", 32'(want.pressed_mask),
                                  32'(o_out_data.pressed_mask));
                if (o_out_data.red !== want.red)
                    flag_mismatch("red", 32'(want.red), 32'(o_out_data.red));
                if (o_out_data.green !== want.green)
                    flag_mismatch("green", 32'(want.green), 32'(o_out_data.green));
                if (o_out_data.blue !== want.blue)
                    flag_mismatch("blue", 32'(want.blue), 32'(o_out_data.blue));
                if (o_out_data.calibrated_mask !== want.calibrated_mask)
                    flag_mismatch("calibrated_mask", 32'(want.calibrated_mask),
                                  32'(o_out_data.calibrated_mask));
            end
        end
        if (recv_stall > 0) begin
            recv_stall--;
            nr = 1'b0;
        end else if (busy_pct != 0 && $urandom_range(0, 99) < busy_pct) begin
            recv_stall = $urandom_range(1, 10) - 1;
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        out_ready <= nr;
    end

    always @(posedge i_clk) begin : drive_regs
        logic       nv;
        t_reg_write nw;
        nv = cfg_valid;
        nw = cfg_word;
        if (cfg_valid && o_cfg_ready) begin
            case (cfg_word.idx)
                REG_DEFAULT_THRESHOLD: cfg_default = cfg_word.value;
                REG_MIN_DELTA:         cfg_delta = cfg_word.value;
                default: begin
                end
            endcase
            nv = 1'b0;
        end
        if (i_rst_n && !nv && reg_writes.size() != 0) begin
            nv = 1'b1;
            nw = reg_writes.pop_front();
        end
        cfg_valid <= nv;
        cfg_word <= nw;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || pad_results_due.size() != 0 ||
               reg_writes.size() != 0 || cfg_valid) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_regs(t_word dflt, t_word delta);
        t_reg_write w;
        w.idx = REG_DEFAULT_THRESHOLD;
        w.value = dflt;
        reg_writes.push_back(w);
        w.idx = REG_MIN_DELTA;
        w.value = delta;
        reg_writes.push_back(w);
        wait_idle();
    endtask

    task automatic gen_session(inout int made);
        t_word base [LIVE_PADS];
        t_word s [LIVE_PADS];
        t_word word;
        int    span;
        int    frames;
        int    detects;
        if ($urandom_range(0, 99) < 12) begin
            pending_items.push_back(build_item(OP_W'($urandom_range(0, OP_SPARE_LAST)),
                                               rand_pad(), rand_word(), rand_word(),
                                               rand_word(), rand_word(), rand_word()));
            made++;
            return;
        end
        span = $urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom_range(0, 6000);
        for (int i = 0; i < LIVE_PADS; i++) begin
            base[i] = $urandom_range(0, 1) ? t_word'($urandom_range(0, 300)) : rand_word();
        end
        if ($urandom_range(0, 5) != 0) begin
            pending_items.push_back(build_item(OP_START, rand_pad(), rand_word(),
                                               rand_word(), rand_word(), rand_word(),
                                               rand_word()));
            made++;
        end
        frames = $urandom_range(1, 5);
        repeat (frames) begin
            for (int i = 0; i < LIVE_PADS; i++) s[i] = near_reading(base[i], span);
            pending_items.push_back(build_item(OP_FRAME, rand_pad(), rand_word(),
                                               s[0], s[1], s[2], s[3]));
            made++;
        end
        if ($urandom_range(0, 7) != 0) begin
            pending_items.push_back(build_item(OP_FINISH, rand_pad(), rand_word(),
                                               rand_word(), rand_word(), rand_word(),
                                               rand_word()));
            made++;
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       word = '0;
                1:       word = WORD_ONES;
                default: word = rand_word();
            endcase
            pending_items.push_back(build_item(OP_LOAD, rand_pad(), word,
                                               rand_word(), rand_word(), rand_word(),
                                               rand_word()));
            made++;
        end
        detects = $urandom_range(1, 4);
        repeat (detects) begin
            for (int i = 0; i < LIVE_PADS; i++) s[i] = near_reading(base[i], span);
            pending_items.push_back(build_item(OP_DETECT, rand_pad(), rand_word(),
                                               s[0], s[1], s[2], s[3]));
            made++;
        end
    endtask

    task automatic run_phase(t_word dflt, t_word delta, int count, int pct);
        int made;
        made = 0;
        write_regs(dflt, delta);
        busy_pct = pct;
        while (made < count) gen_session(made);
        wait_idle();
    endtask

    initial begin
        cfg_default = DEFAULT_THRESHOLD_RST;
        cfg_delta = MIN_DELTA_RST;
        for (int i = 0; i < PAD_COUNT; i++) begin
            low_seen[i] = WORD_ONES;
            high_seen[i] = '0;
            pad_thr[i] = DEFAULT_THRESHOLD_RST;
        end
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        busy_pct = 20;
        pending_items.push_back(build_item(OP_DETECT, 0, 0, 0, 39, 40, WORD_ONES));
        pending_items.push_back(build_item(OP_DETECT, 3, WORD_ONES, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_SPARE_FIRST, 2, rand_word(), rand_word(),
                                           rand_word(), rand_word(), rand_word()));
        pending_items.push_back(build_item(OP_SPARE_LAST, 1, rand_word(), rand_word(),
                                           rand_word(), rand_word(), rand_word()));
        // Frame and finish without a start, all pads flat.
        pending_items.push_back(build_item(OP_FRAME, 0, 0, 100, 200, 300, 400));
        pending_items.push_back(build_item(OP_FINISH, 0, 0, 0, 0, 0, 0));
        // Full spread, spread one short of the minimum, spread exactly at it, flat.
        pending_items.push_back(build_item(OP_START, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_FRAME, 0, 0, 0, 1000, 500, 0));
        pending_items.push_back(build_item(OP_FRAME, 0, 0, WORD_ONES, 1009, 510, 0));
        pending_items.push_back(build_item(OP_FINISH, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_DETECT, 0, 0, 26213, 0, 503, 39));
        pending_items.push_back(build_item(OP_DETECT, 0, 0, 26214, 40, 504, 40));
        pending_items.push_back(build_item(OP_START, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_FINISH, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_LOAD, 0, '0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_LOAD, 1, WORD_ONES, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_LOAD, 2, 1, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_LOAD, 3, 16'hFFFE, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_DETECT, 0, 0, 39, 40, 0, 16'hFFFD));
        wait_idle();

        write_regs('0, '0);
        pending_items.push_back(build_item(OP_START, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_FRAME, 0, 0, 5, 7, 0, 9));
        pending_items.push_back(build_item(OP_FRAME, 0, 0, 6, 7, WORD_ONES, 9));
        pending_items.push_back(build_item(OP_FINISH, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_DETECT, 0, 0, 4, 0, 0, 8));
        pending_items.push_back(build_item(OP_LOAD, 3, '0, 0, 0, 0, 0));
        wait_idle();

        write_regs(WORD_ONES, WORD_ONES);
        pending_items.push_back(build_item(OP_START, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_FRAME, 0, 0, 0, 0, 1, 7));
        pending_items.push_back(build_item(OP_FRAME, 0, 0, WORD_ONES, 16'hFFFE, WORD_ONES, 7));
        pending_items.push_back(build_item(OP_FINISH, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_LOAD, 2, WORD_ONES, 0, 0, 0, 0));
        pending_items.push_back(build_item(OP_DETECT, 0, 0, 16'hFFFE, 16'hFFFE, 16'hFFFE,
                                           WORD_ONES));
        wait_idle();

        run_phase(DEFAULT_THRESHOLD_RST, MIN_DELTA_RST, 110, 15);
        run_phase('0, '0, 110, 10);
        run_phase(WORD_ONES, WORD_ONES, 100, 30);
        run_phase(rand_word(), t_word'($urandom_range(0, 300)), 110, 20);
        run_phase(t_word'($urandom_range(0, 8000)), t_word'($urandom_range(0, 50)), 120, 0);

        repeat (6) @(negedge i_clk);
        if (mismatch_count == 0 && pad_results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
